// ===== hdl/slm3b_pkg.sv =====
// ----------------------------------------------------------------------------
// slm3b_pkg
// shared widths, codes, coefficient tables and the sample magnitude function
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slm3b_pkg;

  localparam int unsigned SampleW  = 32;
  localparam int unsigned MagW     = 24;  // q1.23 magnitude, max 1.0
  localparam int unsigned SumW     = 40;
  localparam int unsigned CntW     = 17;
  localparam int unsigned LevelW   = 24;  // q8.16
  localparam int unsigned OutW     = 17;  // q1.16
  localparam int unsigned DivW     = 44;  // dividend / quotient width
  localparam int unsigned RemW     = 17;
  localparam int unsigned MulAW    = 24;
  localparam int unsigned MulBW    = 18;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned AccW     = 64;
  localparam int unsigned StepW    = 6;
  localparam int unsigned BandW    = 2;
  localparam int unsigned NumBands = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;

  localparam logic [CntW-1:0]   MaxPacketFrames = 17'd65536;
  localparam logic [MagW-1:0]   OneQ23          = 24'h800000;
  localparam logic [LevelW-1:0] ClampQ16        = 24'd98304;
  localparam logic [MulBW-1:0]  DecayQ16        = 18'd57672;
  // floor(x / 3) = (x * Recip3) >> 19 for every x below 2^19
  localparam logic [MulBW-1:0]  Recip3          = 18'd174763;

  // sample formats
  localparam logic [1:0] FmtS16 = 2'd0;
  localparam logic [1:0] FmtS24 = 2'd1;
  localparam logic [1:0] FmtF32 = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSampleFormat = 1'd0;
  localparam logic [CfgIdxW-1:0] RegMonoInput    = 1'd1;

  // last step of each controller sequence, and the last band
  localparam logic [StepW-1:0] DivLast = 6'(DivW - 1);
  localparam logic [StepW-1:0] UpdLast = 6'd4;
  localparam logic [StepW-1:0] RdLast  = 6'd2;
  localparam logic [BandW-1:0] BandLast = 2'(NumBands - 1);

  typedef enum logic [2:0] {
    MUL_LVL_KEEP,
    MUL_S_LO,
    MUL_S_HI,
    MUL_CLAMP,
    MUL_DECAY
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_e;

  typedef struct packed {
    logic             frame_acc;
    logic             div_init;
    logic             div_step;
    mul_sel_e         mul_sel;
    acc_op_e          acc_op;
    logic             lvl_sat_wr;
    logic             lvl_decay_wr;
    logic             out_wr;
    logic             out_set;
    logic [BandW-1:0] band;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // keep coefficient, q0.16
  function automatic logic [MulBW-1:0] keep_of(input logic [BandW-1:0] band);
    logic [MulBW-1:0] r;
    case (band)
      2'd0:    r = 18'd45875;
      2'd1:    r = 18'd47186;
      default: r = 18'd49152;
    endcase
    return r;
  endfunction

  // band weight times gain coefficient
  function automatic logic [MulBW-1:0] wg_of(input logic [BandW-1:0] band);
    logic [MulBW-1:0] r;
    case (band)
      2'd0:    r = 18'd235932;
      2'd1:    r = 18'd110100;
      default: r = 18'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [MagW-1:0] magnitude(input logic [SampleW-1:0] w,
                                                input logic [1:0]         fmt);
    logic [15:0]     v16;
    logic [16:0]     m17;
    logic [23:0]     v24;
    logic [24:0]     m25;
    logic [7:0]      e;
    logic [7:0]      sh;
    logic [23:0]     mant;
    logic [MagW-1:0] r;
    v16  = w[15:0];
    v24  = w[23:0];
    e    = w[30:23];
    mant = {1'b1, w[22:0]};
    sh   = 8'd127 - e;
    m17  = v16[15] ? (17'h10000 - {1'b0, v16}) : {1'b0, v16};
    m25  = v24[23] ? (25'h1000000 - {1'b0, v24}) : {1'b0, v24};
    case (fmt)
      FmtS16: r = {m17[15:0], 8'h00};
      FmtS24: r = m25[23:0];
      FmtF32: begin
        if (e >= 8'd127) begin
          r = OneQ23;
        end else if (e == 8'd0) begin
          r = '0;
        end else if (sh >= 8'd24) begin
          r = '0;
        end else begin
          r = mant >> sh[4:0];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/slm3b_ctrl.sv =====
// ----------------------------------------------------------------------------
// slm3b_ctrl
// sequencer for frame intake, packet division, level update and level read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slm3b_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_opcode_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  input  slm3b_pkg::status_t status_i,
  output slm3b_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDInit = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StUpd   = 3'd3;
  localparam logic [2:0] StRWait = 3'd4;
  localparam logic [2:0] StRd    = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [slm3b_pkg::StepW-1:0] step_q, step_d;
  logic [slm3b_pkg::BandW-1:0] band_q, band_d;
  logic                        accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    band_d  = band_q;
    cmd_o   = '0;
    cmd_o.mul_sel = slm3b_pkg::MUL_LVL_KEEP;
    cmd_o.acc_op  = slm3b_pkg::ACC_HOLD;
    cmd_o.band    = band_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_opcode_i) begin
            state_d = StRWait;
          end else begin
            cmd_o.frame_acc = 1'b1;
            if (in_last_i) begin
              state_d = StDInit;
            end
          end
        end
      end
      StDInit: begin
        cmd_o.div_init = 1'b1;
        step_d  = '0;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (step_q == slm3b_pkg::DivLast) begin
          step_d  = '0;
          band_d  = '0;
          state_d = StUpd;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StUpd: begin
        case (step_q)
          6'd0: cmd_o.mul_sel = slm3b_pkg::MUL_LVL_KEEP;
          6'd1: begin
            cmd_o.acc_op  = slm3b_pkg::ACC_LOAD;
            cmd_o.mul_sel = slm3b_pkg::MUL_S_LO;
          end
          6'd2: begin
            cmd_o.acc_op  = slm3b_pkg::ACC_ADD;
            cmd_o.mul_sel = slm3b_pkg::MUL_S_HI;
          end
          6'd3: cmd_o.acc_op = slm3b_pkg::ACC_ADD_HI;
          default: cmd_o.lvl_sat_wr = 1'b1;
        endcase
        if (step_q == slm3b_pkg::UpdLast) begin
          step_d = '0;
          if (band_q == slm3b_pkg::BandLast) begin
            state_d = StIdle;
          end else begin
            band_d = band_q + 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StRWait: begin
        if (!status_i.out_busy) begin
          step_d  = '0;
          band_d  = '0;
          state_d = StRd;
        end
      end
      StRd: begin
        case (step_q)
          6'd0: cmd_o.mul_sel = slm3b_pkg::MUL_CLAMP;
          6'd1: begin
            cmd_o.out_wr  = 1'b1;
            cmd_o.mul_sel = slm3b_pkg::MUL_DECAY;
          end
          default: cmd_o.lvl_decay_wr = 1'b1;
        endcase
        if (step_q == slm3b_pkg::RdLast) begin
          step_d = '0;
          if (band_q == slm3b_pkg::BandLast) begin
            cmd_o.out_set = 1'b1;
            state_d = StIdle;
          end else begin
            band_d = band_q + 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      band_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      band_q  <= band_d;
    end
  end

endmodule

// ===== hdl/slm3b_datapath.sv =====
// ----------------------------------------------------------------------------
// slm3b_datapath
// accumulator, radix-2 divider, shared multiplier, levels and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slm3b_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  slm3b_pkg::cmd_t                    cmd_i,
  output slm3b_pkg::status_t                 status_o,
  input  logic                               cfg_we_i,
  input  logic [slm3b_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [slm3b_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic [slm3b_pkg::SampleW-1:0]      left_word_i,
  input  logic [slm3b_pkg::SampleW-1:0]      right_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [slm3b_pkg::OutW-1:0]         low_level_o,
  output logic [slm3b_pkg::OutW-1:0]         mid_level_o,
  output logic [slm3b_pkg::OutW-1:0]         high_level_o
);

  localparam int unsigned SumW   = slm3b_pkg::SumW;
  localparam int unsigned MagW   = slm3b_pkg::MagW;
  localparam int unsigned LevelW = slm3b_pkg::LevelW;
  localparam int unsigned DivW   = slm3b_pkg::DivW;
  localparam int unsigned RemW   = slm3b_pkg::RemW;
  localparam int unsigned CntW   = slm3b_pkg::CntW;
  localparam int unsigned ProdW  = slm3b_pkg::ProdW;
  localparam int unsigned AccW   = slm3b_pkg::AccW;
  localparam int unsigned OutW   = slm3b_pkg::OutW;
  localparam int unsigned MulAW  = slm3b_pkg::MulAW;
  localparam int unsigned MulBW  = slm3b_pkg::MulBW;
  localparam int unsigned NumBands = slm3b_pkg::NumBands;

  // configuration
  logic [1:0] fmt_q;
  logic       mono_q;

  // packet state
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [LevelW-1:0] lvl_q [NumBands];

  // divider
  logic [DivW-1:0] quo_q;
  logic [RemW-1:0] rem_q;
  logic [CntW-1:0] div_q;

  // multiplier and accumulator
  logic [ProdW-1:0] prod_q, prod_d;
  logic [AccW-1:0]  acc_q, acc_d;

  // output register
  logic            out_valid_q;
  logic [OutW-1:0] out_q [NumBands];

  // frame accumulate
  logic [MagW-1:0]   mag_l, mag_r, mean;
  logic [MagW:0]     pair;
  logic [SumW:0]     sum_ext;
  logic [DivW-1:0]   dividend;
  logic [RemW:0]     rem_sh;
  logic              rem_ge;
  logic [LevelW-1:0] lvl_sel, lvl_clamp, sat_val;
  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;

  assign mag_l   = slm3b_pkg::magnitude(left_word_i, fmt_q);
  assign mag_r   = mono_q ? mag_l : slm3b_pkg::magnitude(right_word_i, fmt_q);
  assign pair    = {1'b0, mag_l} + {1'b0, mag_r};
  assign mean    = pair[MagW:1];
  assign sum_ext = {1'b0, sum_q} + (SumW + 1)'(mean);

  always_comb begin
    sum_d = sum_ext[SumW] ? {SumW{1'b1}} : sum_ext[SumW-1:0];
    cnt_d = (cnt_q == slm3b_pkg::MaxPacketFrames) ? cnt_q : cnt_q + 1'b1;
  end

  // sum * 10 as two shifted copies
  assign dividend = DivW'({sum_q, 3'b000}) + DivW'({sum_q, 1'b0});

  // restoring division step
  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign rem_ge = (rem_sh >= {1'b0, div_q});

  // operand select for the shared multiplier
  always_comb begin
    case (cmd_i.band)
      2'd0:    lvl_sel = lvl_q[0];
      2'd1:    lvl_sel = lvl_q[1];
      default: lvl_sel = lvl_q[2];
    endcase
    lvl_clamp = (lvl_sel > slm3b_pkg::ClampQ16) ? slm3b_pkg::ClampQ16 : lvl_sel;
    case (cmd_i.mul_sel)
      slm3b_pkg::MUL_LVL_KEEP: begin
        mul_a = lvl_sel;
        mul_b = slm3b_pkg::keep_of(cmd_i.band);
      end
      slm3b_pkg::MUL_S_LO: begin
        mul_a = MulAW'(quo_q[21:0]);
        mul_b = slm3b_pkg::wg_of(cmd_i.band);
      end
      slm3b_pkg::MUL_S_HI: begin
        mul_a = MulAW'(quo_q[DivW-1:22]);
        mul_b = slm3b_pkg::wg_of(cmd_i.band);
      end
      slm3b_pkg::MUL_CLAMP: begin
        mul_a = {lvl_clamp[LevelW-2:0], 1'b0};
        mul_b = slm3b_pkg::Recip3;
      end
      slm3b_pkg::MUL_DECAY: begin
        mul_a = lvl_sel;
        mul_b = slm3b_pkg::DecayQ16;
      end
      default: begin
        mul_a = lvl_sel;
        mul_b = slm3b_pkg::DecayQ16;
      end
    endcase
  end

  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  always_comb begin
    case (cmd_i.acc_op)
      slm3b_pkg::ACC_LOAD:   acc_d = AccW'({prod_q, 7'b0});
      slm3b_pkg::ACC_ADD:    acc_d = acc_q + AccW'(prod_q);
      slm3b_pkg::ACC_ADD_HI: acc_d = acc_q + AccW'({prod_q, 22'b0});
      default:               acc_d = acc_q;
    endcase
  end

  assign sat_val = (|acc_q[AccW-1:47]) ? {LevelW{1'b1}} : acc_q[46:23];

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= slm3b_pkg::FmtS16;
      mono_q      <= 1'b0;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumBands; i++) begin
        lvl_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          slm3b_pkg::RegSampleFormat: fmt_q  <= cfg_data_i[1:0];
          slm3b_pkg::RegMonoInput:    mono_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.frame_acc) begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end else if (cmd_i.div_init) begin
        sum_q <= '0;
        cnt_q <= '0;
      end
      for (int i = 0; i < NumBands; i++) begin
        if (cmd_i.band == slm3b_pkg::BandW'(i)) begin
          if (cmd_i.lvl_sat_wr) begin
            lvl_q[i] <= sat_val;
          end else if (cmd_i.lvl_decay_wr) begin
            lvl_q[i] <= prod_q[39:16];
          end
        end
      end
      if (cmd_i.out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.div_init) begin
      quo_q <= dividend;
      rem_q <= '0;
      div_q <= cnt_q + 1'b1;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DivW-2:0], rem_ge};
      rem_q <= rem_ge ? RemW'(rem_sh - {1'b0, div_q}) : rem_sh[RemW-1:0];
    end
    for (int i = 0; i < NumBands; i++) begin
      if (cmd_i.out_wr && cmd_i.band == slm3b_pkg::BandW'(i)) begin
        out_q[i] <= prod_q[35:19];
      end
    end
  end

  assign status_o.out_busy = out_valid_q;
  assign out_valid_o       = out_valid_q;
  assign low_level_o       = out_q[0];
  assign mid_level_o       = out_q[1];
  assign high_level_o      = out_q[2];

endmodule

// ===== hdl/stereo_level_meter_three_band.sv =====
// ----------------------------------------------------------------------------
// stereo_level_meter_three_band
// three-band stereo level meter with packet averaging and leaky levels
// sequence: a frame word leaves the input ready unless marked last; a frame word marked
//   last then holds the input for a setup step, 44 divide steps and 15 update steps
// a read word waits until the output register is free, then runs a clamp, output and decay
//   step per band; its levels appear in the same cycle as the input is ready again
// throughput: one frame word per cycle inside a packet, set by the accumulator, except
//   while a read word is served; packet end and reads share one 24x18 multiplier
// reset: asynchronous active low; clears control, configuration and valid registers, levels and packet sums
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_level_meter_three_band (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // left_word [31:0], right_word [63:32]
  input  logic [0:0]  s_axis_tuser,  // opcode [0]
  input  logic        s_axis_tlast,  // last_frame
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata   // low [16:0], mid [33:17], high [50:34], zero pad
);

  slm3b_pkg::cmd_t    cmd;
  slm3b_pkg::status_t status;

  logic [slm3b_pkg::OutW-1:0] low_level, mid_level, high_level;

  // sequencer: decides what the datapath does each cycle
  slm3b_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser[0]),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: accumulator, divider, multiplier, levels and result register
  slm3b_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .left_word_i  (s_axis_tdata[31:0]),
    .right_word_i (s_axis_tdata[63:32]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .low_level_o  (low_level),
    .mid_level_o  (mid_level),
    .high_level_o (high_level)
  );

  // pack the three levels low first, pad to whole bytes
  assign m_axis_tdata = {5'b0, high_level, mid_level, low_level};

endmodule

// ===== hdl/slm3b_checker.sv =====
// ----------------------------------------------------------------------------
// slm3b_checker
// port-level checks on the level meter's handshakes and sequencing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slm3b_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // result word stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // a read word occupies the block for its read sequence
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tuser[0]) |=> !s_axis_tready)
    else $error("input ready right after a read word");

  // a packet end starts the divide and update sequence
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !s_axis_tuser[0] && s_axis_tlast) |=> !s_axis_tready)
    else $error("input ready right after a packet end");

  // a frame word never makes a result appear
  a_frame_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !s_axis_tuser[0] && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("result word appeared after a frame word");

endmodule

bind stereo_level_meter_three_band slm3b_checker u_slm3b_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
